FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the scan-to-points block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check on every clock edge outside reset.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: rtl/stc_pkg.sv
// Types, constants and tables for the scan-to-points block.
`timescale 1ns / 1ps
package stc_pkg;

  localparam int MAX_BEAMS    = 4096;
  localparam int CORDIC_STEPS = 16;

  // Field widths
  localparam int RANGE_W = 16;
  localparam int ANGLE_W = 16;
  localparam int COORD_W = 17;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP  = 2'd1;

  // CORDIC datapath widths
  localparam int XW      = 35;          // x, y with 16 fraction bits
  localparam int ZW      = 33;          // angle accumulator, 2^32 per turn
  localparam int ATAN_W  = 30;
  localparam int GAIN_W  = 30;
  localparam int PROD_W  = RANGE_W + GAIN_W;
  localparam int RND_W   = XW - 16;
  localparam int LUT_IDX_W = 5;
  localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;
  localparam int OUT_LIMIT = 65535;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_GAIN,
    CS_ITER,
    CS_ROUND,
    CS_HOLD
  } cordic_state_e;

  // Request from the control side to the CORDIC unit
  typedef struct packed {
    logic               start;
    logic               take;
    logic [RANGE_W-1:0] range_mm;
    logic [ANGLE_W-1:0] angle;
  } cordic_req_t;

  // Result of the CORDIC unit
  typedef struct packed {
    logic                      done;
    logic signed [COORD_W-1:0] x_mm;
    logic signed [COORD_W-1:0] y_mm;
  } cordic_rsp_t;

  // round(atan(2^-i) / (2 pi) * 2^32)
  function automatic logic [ATAN_W-1:0] atan_lut(input logic [LUT_IDX_W-1:0] i);
    logic [ATAN_W-1:0] v;
    case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/stc_if.sv
// Valid/ready stream interfaces for scanner samples and points.
`timescale 1ns / 1ps
interface stc_in_if;
  logic                          valid;
  logic                          ready;
  logic [stc_pkg::RANGE_W-1:0]   range_mm;
  logic                          range_invalid;
  logic                          scan_start;

  modport source (output valid, range_mm, range_invalid, scan_start, input ready);
  modport sink   (input valid, range_mm, range_invalid, scan_start, output ready);
endinterface

interface stc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [stc_pkg::COORD_W-1:0] x_mm;
  logic signed [stc_pkg::COORD_W-1:0] y_mm;

  modport source (output valid, x_mm, y_mm, input ready);
  modport sink   (input valid, x_mm, y_mm, output ready);
endinterface

FILE: rtl/stc_cordic.sv
// Iterative CORDIC rotation unit: gain, one micro-rotation per cycle, rounding.
`timescale 1ns / 1ps
module stc_cordic #(
  parameter int CORDIC_STEPS = stc_pkg::CORDIC_STEPS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  stc_pkg::cordic_req_t req_i,
  output stc_pkg::cordic_rsp_t rsp_o
);

  localparam int CNT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int XW    = stc_pkg::XW;
  localparam int ZW    = stc_pkg::ZW;
  localparam int RW    = stc_pkg::RND_W;

  stc_pkg::cordic_state_e state_q, state_d;

  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic signed [XW-1:0]          x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0]          z_q, z_d;
  logic                          flip_q, flip_d;
  logic signed [stc_pkg::COORD_W-1:0] xo_q, xo_d, yo_q, yo_d;

  // Saturate a rounded coordinate to the output range
  function automatic logic signed [stc_pkg::COORD_W-1:0] clamp_out(
      input logic signed [RW:0] v);
    logic signed [stc_pkg::COORD_W-1:0] r;
    if (v > (RW+1)'(stc_pkg::OUT_LIMIT)) begin
      r = stc_pkg::COORD_W'(stc_pkg::OUT_LIMIT);
    end else if (v < -(RW+1)'(stc_pkg::OUT_LIMIT)) begin
      r = -stc_pkg::COORD_W'(stc_pkg::OUT_LIMIT);
    end else begin
      r = v[stc_pkg::COORD_W-1:0];
    end
    return r;
  endfunction

  // Quadrant fold of the beam angle
  logic                         fold;
  logic [stc_pkg::ANGLE_W-1:0]  ang_f;
  logic signed [ZW-1:0]         z0;
  assign fold  = req_i.angle[15] ^ req_i.angle[14];
  assign ang_f = {req_i.angle[15] ^ fold, req_i.angle[14:0]};
  assign z0    = $signed({ang_f[15], ang_f, 16'h0000});

  // Gain-compensated start value
  logic [stc_pkg::PROD_W-1:0] gprod;
  logic signed [XW-1:0]       x0;
  assign gprod = stc_pkg::PROD_W'(req_i.range_mm) * stc_pkg::PROD_W'(stc_pkg::GAIN_Q30)
               + stc_pkg::PROD_W'(8192);
  assign x0    = $signed({3'b000, gprod[stc_pkg::PROD_W-1:14]});

  // Shared micro-rotation unit
  logic signed [XW-1:0] dx, dy;
  logic signed [ZW-1:0] at;
  assign dx = y_q >>> cnt_q;
  assign dy = x_q >>> cnt_q;
  assign at = $signed({{(ZW-stc_pkg::ATAN_W){1'b0}},
                       stc_pkg::atan_lut(stc_pkg::LUT_IDX_W'(cnt_q))});

  // Rounding to millimetres
  logic signed [XW-1:0] xs, ys;
  logic signed [RW:0]   xe, ye, xn, yn;
  assign xs = x_q + XW'(32768);
  assign ys = y_q + XW'(32768);
  assign xe = {xs[XW-1], xs[XW-1:16]};
  assign ye = {ys[XW-1], ys[XW-1:16]};
  assign xn = flip_q ? -xe : xe;
  assign yn = flip_q ? -ye : ye;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      stc_pkg::CS_IDLE:  if (req_i.start) state_d = stc_pkg::CS_GAIN;
      stc_pkg::CS_GAIN:  state_d = stc_pkg::CS_ITER;
      stc_pkg::CS_ITER:  if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) state_d = stc_pkg::CS_ROUND;
      stc_pkg::CS_ROUND: state_d = stc_pkg::CS_HOLD;
      stc_pkg::CS_HOLD:  if (req_i.take) state_d = stc_pkg::CS_IDLE;
      default:           state_d = stc_pkg::CS_IDLE;
    endcase
  end

  // Datapath
  always_comb begin
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    flip_d = flip_q;
    xo_d   = xo_q;
    yo_d   = yo_q;
    case (state_q)
      stc_pkg::CS_GAIN: begin
        x_d    = x0;
        y_d    = '0;
        z_d    = z0;
        flip_d = fold;
        cnt_d  = '0;
      end
      stc_pkg::CS_ITER: begin
        if (!z_q[ZW-1]) begin
          x_d = x_q - dx;
          y_d = y_q + dy;
          z_d = z_q - at;
        end else begin
          x_d = x_q + dx;
          y_d = y_q - dy;
          z_d = z_q + at;
        end
        cnt_d = cnt_q + CNT_W'(1);
      end
      stc_pkg::CS_ROUND: begin
        xo_d = clamp_out(xn);
        yo_d = clamp_out(yn);
      end
      default: ;
    endcase
  end

  // Outputs: the rounded word is ready while holding
  assign rsp_o.done = (state_q == stc_pkg::CS_HOLD);
  assign rsp_o.x_mm = xo_q;
  assign rsp_o.y_mm = yo_q;

  // Hold the sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stc_pkg::CS_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Hold the datapath words
  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    flip_q <= flip_d;
    xo_q   <= xo_d;
    yo_q   <= yo_d;
  end

endmodule

FILE: rtl/scan_to_cartesian_points.sv
// Top level of the scan-to-points block: handshakes, registers, beam index, output word.
`timescale 1ns / 1ps
// Turns range-scanner samples into Cartesian points (x_mm, y_mm). The beam angle is
// start_angle + beam_index * angle_step in binary angle units; the index restarts on
// scan_start and stops at MAX_BEAMS-1. An invalid sample is taken without making the
// input side busy and gives no word. A valid sample keeps the input side busy until
// its word leaves the unit: one shared add/shift stage performs one CORDIC micro-rotation
// per cycle, framed by angle, gain and rounding steps. The finished
// word waits in an output register, so the next sample is taken while it is pending;
// while that register still holds an untaken word, the input stays busy longer.
module scan_to_cartesian_points #(
  parameter int MAX_BEAMS    = stc_pkg::MAX_BEAMS,
  parameter int CORDIC_STEPS = stc_pkg::CORDIC_STEPS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  stc_in_if.sink                          in_i,
  stc_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [stc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [stc_pkg::CFG_W-1:0]       cfg_data_i
);

  `include "assert_macros.svh"

  localparam int IDX_W = $clog2(MAX_BEAMS);

  logic [stc_pkg::ANGLE_W-1:0] start_angle_q, angle_step_q;
  logic [IDX_W-1:0]            idx_q, idx_d, idx_use;
  logic                        busy_q, start_q, out_valid_q;
  logic [stc_pkg::RANGE_W-1:0] range_q;
  logic [stc_pkg::ANGLE_W-1:0] angle_q, angle_d;
  logic signed [stc_pkg::COORD_W-1:0] x_q, y_q;
  logic                        accept, out_load;
  logic [31:0]                 step_prod;

  stc_pkg::cordic_req_t req;
  stc_pkg::cordic_rsp_t rsp;

  assign in_i.ready = !busy_q;
  assign accept     = in_i.valid && in_i.ready;

  // Beam index for this sample and the one after it
  assign idx_use   = in_i.scan_start ? '0 : idx_q;
  assign idx_d     = (idx_use == IDX_W'(MAX_BEAMS - 1)) ? idx_use : idx_use + IDX_W'(1);
  assign step_prod = 32'(idx_use) * 32'(angle_step_q);
  assign angle_d   = start_angle_q + step_prod[stc_pkg::ANGLE_W-1:0];

  // Move the finished word to the output register when it is free
  assign out_load = rsp.done && (!out_valid_q || out_o.ready);

  assign req.start    = start_q;
  assign req.take     = out_load;
  assign req.range_mm = range_q;
  assign req.angle    = angle_q;

  stc_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_angle_q <= '0;
      angle_step_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        stc_pkg::CFG_START_ANGLE: start_angle_q <= cfg_data_i;
        stc_pkg::CFG_ANGLE_STEP:  angle_step_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance the index, launch the unit, track busy and the output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      busy_q      <= 1'b0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      start_q <= accept && !in_i.range_invalid;
      if (accept) begin
        idx_q <= idx_d;
        if (!in_i.range_invalid) begin
          busy_q <= 1'b1;
        end
      end
      if (out_load) begin
        busy_q      <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the sample payload and the result word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      range_q <= in_i.range_mm;
      angle_q <= angle_d;
    end
    if (out_load) begin
      x_q <= rsp.x_mm;
      y_q <= rsp.y_mm;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.x_mm  = x_q;
  assign out_o.y_mm  = y_q;

  `ASSERT_RST(a_load_only_busy, out_load |-> busy_q, "result word without a sample in work")
  `ASSERT_RST(a_idx_bound, idx_q <= IDX_W'(MAX_BEAMS - 1), "beam index past its end")
  `ASSERT_RST(a_drop_invalid, accept && in_i.range_invalid |=> !busy_q && !start_q, "invalid sample started work")
  `ASSERT_RST(a_start_follows, start_q |-> $past(accept), "unit launched without an accepted sample")

endmodule
